### rtl/dtq_pkg.sv
`default_nettype none

package dtq_pkg;

  localparam int ITEM_W     = 6;
  localparam int REQ_W      = 2;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;

  // request codes carried on in_tuser
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FILL   = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_CHK,
    S_RM_HEAD,
    S_RM_FLAG,
    S_FILL_RD,
    S_FILL_WR
  } dtq_state_t;

endpackage

`default_nettype wire

### rtl/dedup_todo_queue.sv
// Deduplicating queue of item numbers 0 to QUEUE_SIZE-1.
// Input channel (in_*): in_tuser carries the request kind (add, remove, fill),
// in_tdata the item number for an add. A request is taken when in_tvalid and
// in_tready are both high; in_tready is high only while the sequencer is idle.
// Output channel (out_*): one result per remove request, out_tdata holding the
// removed item and out_tuser set when an item was taken (clear on empty queue).
// Adds, fills and the unused request code give no result.
// Steps of each request, from acceptance until the next request can be taken:
//   add     flag read, then ring and flag write
//   remove  ring read at the out pointer, flag read, result load once output is free
//   fill    flag read and conditional write for each of the QUEUE_SIZE items
// These steps are set by the single-port flag memory that every step goes
// through. An add of an item outside the queue range or the unused code
// returns to idle at once.
// Reset (rst_n low, synchronous) clears the pointers and starts a pass that
// clears every entry of the flag and ring memories, one entry of each per cycle;
// no request is taken meanwhile.
// The result sits in an output register: a stalled receiver holds it there,
// further requests are still taken, and only the next remove waits for it.
`default_nettype none

module dedup_todo_queue #(
  parameter int QUEUE_SIZE = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [dtq_pkg::IN_DATA_W-1:0]   in_tdata,   // [5:0] item, [7:6] zero
  input  logic [dtq_pkg::REQ_W-1:0]       in_tuser,   // [1:0] req_type
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dtq_pkg::OUT_DATA_W-1:0]  out_tdata,  // [5:0] removed_item, [7:6] zero
  output logic                            out_tuser   // [0] got_item
);
  import dtq_pkg::*;

  localparam int PW = (QUEUE_SIZE > 1) ? $clog2(QUEUE_SIZE) : 1;
  localparam int KW = (PW > ITEM_W) ? PW : ITEM_W;
  localparam logic [KW:0]   SIZE_K = (KW+1)'(QUEUE_SIZE);
  localparam logic [PW-1:0] LAST_P = PW'(QUEUE_SIZE - 1);

  logic [PW-1:0] ring_mem [QUEUE_SIZE];
  logic          flag_mem [QUEUE_SIZE];

  dtq_state_t        state_r, state_nxt;
  logic [PW-1:0]     in_ptr_r, in_ptr_nxt;
  logic [PW-1:0]     out_ptr_r, out_ptr_nxt;
  logic [PW-1:0]     cnt_r, cnt_nxt;
  logic [PW-1:0]     item_r, item_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [ITEM_W-1:0] out_item_r, out_item_nxt;
  logic              out_got_r, out_got_nxt;

  logic          ring_we;
  logic [PW-1:0] ring_waddr;
  logic [PW-1:0] ring_wdata;
  logic [PW-1:0] ring_q;
  logic          flag_we;
  logic          flag_wdata;
  logic [PW-1:0] flag_addr;
  logic          flag_q;

  logic          in_acc;
  logic [KW:0]   in_item_k;
  logic          in_item_ok;
  logic [PW-1:0] in_item_p;
  logic [KW-1:0] head_k;
  logic          out_free;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    next_ptr = (p == LAST_P) ? '0 : p + 1'b1;
  endfunction

  assign in_acc     = in_tvalid && in_tready;
  assign in_item_k  = (KW+1)'(in_tdata[ITEM_W-1:0]);
  assign in_item_ok = (in_item_k < SIZE_K);
  assign in_item_p  = in_item_k[PW-1:0];
  assign head_k     = KW'(ring_q);
  assign out_free   = !out_vld_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (cnt_r == LAST_P) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            REQ_ADD:    if (in_item_ok) state_nxt = S_ADD_CHK;
            REQ_REMOVE: state_nxt = S_RM_HEAD;
            REQ_FILL:   state_nxt = S_FILL_RD;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD_CHK: state_nxt = S_IDLE;
      S_RM_HEAD: state_nxt = S_RM_FLAG;
      S_RM_FLAG: begin
        if (out_free) state_nxt = S_IDLE;
      end
      S_FILL_RD: state_nxt = S_FILL_WR;
      S_FILL_WR: begin
        state_nxt = (cnt_r == LAST_P) ? S_IDLE : S_FILL_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs and datapath
  always_comb begin
    in_tready    = 1'b0;
    ring_we      = 1'b0;
    ring_waddr   = in_ptr_r;
    ring_wdata   = item_r;
    flag_we      = 1'b0;
    flag_wdata   = 1'b0;
    flag_addr    = cnt_r;
    in_ptr_nxt   = in_ptr_r;
    out_ptr_nxt  = out_ptr_r;
    cnt_nxt      = cnt_r;
    item_nxt     = item_r;
    out_item_nxt = out_item_r;
    out_got_nxt  = out_got_r;
    out_vld_nxt  = out_tready ? 1'b0 : out_vld_r;
    case (state_r)
      S_CLEAR: begin
        flag_we    = 1'b1;
        ring_we    = 1'b1;
        ring_waddr = cnt_r;
        ring_wdata = '0;
        cnt_nxt    = next_ptr(cnt_r);
      end
      S_IDLE: begin
        in_tready = 1'b1;
        flag_addr = in_item_p;
        item_nxt  = in_item_p;
        if (in_acc) cnt_nxt = '0;
      end
      S_ADD_CHK: begin
        flag_addr = item_r;
        if (!flag_q) begin
          ring_we    = 1'b1;
          flag_we    = 1'b1;
          flag_wdata = 1'b1;
          in_ptr_nxt = next_ptr(in_ptr_r);
        end
      end
      S_RM_HEAD: begin
        flag_addr = ring_q;
      end
      S_RM_FLAG: begin
        flag_addr = ring_q;
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_got_nxt  = flag_q;
          out_item_nxt = flag_q ? head_k[ITEM_W-1:0] : '0;
          if (flag_q) begin
            flag_we     = 1'b1;
            out_ptr_nxt = next_ptr(out_ptr_r);
          end
        end
      end
      S_FILL_RD: begin
        flag_addr = cnt_r;
      end
      S_FILL_WR: begin
        flag_addr  = cnt_r;
        ring_wdata = cnt_r;
        if (!flag_q) begin
          ring_we    = 1'b1;
          flag_we    = 1'b1;
          flag_wdata = 1'b1;
          in_ptr_nxt = next_ptr(in_ptr_r);
        end
        cnt_nxt = next_ptr(cnt_r);
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      in_ptr_r  <= '0;
      out_ptr_r <= '0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      in_ptr_r  <= in_ptr_nxt;
      out_ptr_r <= out_ptr_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_item_r <= out_item_nxt;
    out_got_r  <= out_got_nxt;
  end

  // ring of queued item numbers, read port always at the out pointer
  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[ring_waddr] <= ring_wdata;
    ring_q <= ring_mem[out_ptr_r];
  end

  // present flag per item
  always_ff @(posedge clk) begin
    if (flag_we) flag_mem[flag_addr] <= flag_wdata;
    flag_q <= flag_mem[flag_addr];
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_DATA_W'(out_item_r);
  assign out_tuser  = out_got_r;

endmodule

`default_nettype wire

### rtl/dtq_checker.sv
`default_nettype none

module dtq_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [dtq_pkg::REQ_W-1:0]       in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [dtq_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic                            out_tuser
);
  import dtq_pkg::*;

  logic rm_acc;
  assign rm_acc = in_tvalid && in_tready && (in_tuser == REQ_REMOVE);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // empty-queue result carries a zero item
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("empty result with nonzero item");

  // a remove keeps the input side busy for the head and flag reads
  a_rm_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rm_acc |=> !in_tready ##1 !in_tready)
    else $error("request taken during remove");

  // a fresh result comes only from a remove, after its head read, flag read and result load
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(rm_acc, 3))
    else $error("result without matching remove");

endmodule

bind dedup_todo_queue dtq_checker u_dtq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
